>>> src/wsa_pkg.sv
package wsa_pkg;

  localparam int STORE_DEPTH = 9;
  localparam int SAMPLE_BITS = 12;
  localparam int WIN_BITS    = 4;
  localparam int FRAC_BITS   = 4;
  localparam int AVG_BITS    = 16;
  localparam int IDX_BITS    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(STORE_DEPTH);
  localparam int DIV_BITS    = SUM_BITS + FRAC_BITS;
  localparam int STEP_BITS   = $clog2(DIV_BITS + 1);
  localparam int ADD_BITS    = SUM_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [AVG_BITS-1:0]    average_t;
  typedef logic [WIN_BITS-1:0]    window_t;
  typedef logic [ADD_BITS-1:0]    operand_t;

endpackage

>>> src/wsa_sample_if.sv
interface wsa_sample_if;
  logic             valid;
  logic             ready;
  wsa_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> src/wsa_result_if.sv
interface wsa_result_if;
  logic              valid;
  logic              ready;
  wsa_pkg::average_t average_value;
  logic              ready_res;

  modport source (output valid, output average_value, output ready_res, input ready);
  modport sink   (input valid, input average_value, input ready_res, output ready);
endinterface

>>> src/windowed_sample_average_unit.sv
// A request with window N (1..9; larger settings use 9) sums N stored samples
// through the shared adder, then runs the restoring divider on the same adder,
// one quotient bit (20) per step. A new sample is taken only once the result
// has been accepted. When entry N-1 is empty the divider is skipped and the
// result is zero with ready_res low; window 0 skips the summing as well.
// Reset (synchronous, rst high) clears the sample store, pointer and window.
module windowed_sample_average_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  wsa_pkg::window_t       cfg_data,
  wsa_sample_if.sink             sensor,
  wsa_result_if.source           average
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                       state;
  wsa_pkg::window_t                 window_length;
  wsa_pkg::window_t                 eff_n;
  wsa_pkg::window_t                 wptr;
  wsa_pkg::window_t                 wslot;
  wsa_pkg::window_t                 k;
  wsa_pkg::window_t                 rem;
  wsa_pkg::sample_t                 store [wsa_pkg::STORE_DEPTH];
  wsa_pkg::sample_t                 rd;
  logic [wsa_pkg::SUM_BITS-1:0]     acc;
  logic [wsa_pkg::DIV_BITS-1:0]     quo;
  logic [wsa_pkg::DIV_BITS-1:0]     quo_next;
  logic [wsa_pkg::STEP_BITS-1:0]    step;
  logic [wsa_pkg::WIN_BITS:0]       shifted;
  logic [wsa_pkg::DIV_BITS+wsa_pkg::AVG_BITS-1:0] quo_wide;
  wsa_pkg::average_t                avg_sat;
  wsa_pkg::average_t                avg;
  logic                             rdy;
  logic                             ovalid;
  wsa_pkg::operand_t                op_a;
  wsa_pkg::operand_t                op_b;
  logic                             op_sub;
  logic [wsa_pkg::ADD_BITS:0]       add_res;
  logic                             ge;

  always_comb begin
    if (32'(window_length) > wsa_pkg::STORE_DEPTH) begin
      eff_n = wsa_pkg::WIN_BITS'(wsa_pkg::STORE_DEPTH);
    end else begin
      eff_n = window_length;
    end
  end

  assign wslot   = (wptr >= eff_n) ? '0 : wptr;
  assign rd      = store[k[wsa_pkg::IDX_BITS-1:0]];
  assign shifted = {rem, quo[wsa_pkg::DIV_BITS-1]};

  always_comb begin
    if (state == ST_DIV) begin
      op_a   = wsa_pkg::ADD_BITS'(shifted);
      op_b   = wsa_pkg::ADD_BITS'(eff_n);
      op_sub = 1'b1;
    end else begin
      op_a   = acc;
      op_b   = wsa_pkg::ADD_BITS'(rd);
      op_sub = 1'b0;
    end
  end

  wsa_addsub u_addsub (
    .a      (op_a),
    .b      (op_b),
    .sub    (op_sub),
    .result (add_res)
  );

  assign ge       = add_res[wsa_pkg::ADD_BITS];
  assign quo_next = {quo[wsa_pkg::DIV_BITS-2:0], ge};
  assign quo_wide = (wsa_pkg::DIV_BITS + wsa_pkg::AVG_BITS)'(quo_next);
  assign avg_sat  = (|quo_wide[wsa_pkg::DIV_BITS+wsa_pkg::AVG_BITS-1:wsa_pkg::AVG_BITS])
                    ? '1 : quo_wide[wsa_pkg::AVG_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_length <= '0;
      wptr          <= '0;
      ovalid        <= 1'b0;
      for (int i = 0; i < wsa_pkg::STORE_DEPTH; i++) begin
        store[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        window_length <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (sensor.valid) begin
            if (eff_n != '0) begin
              store[wslot[wsa_pkg::IDX_BITS-1:0]] <= sensor.sample;
              wptr  <= wslot + wsa_pkg::WIN_BITS'(1);
              k     <= '0;
              acc   <= '0;
              state <= ST_SUM;
            end else begin
              wptr   <= wptr + wsa_pkg::WIN_BITS'(1);
              avg    <= '0;
              rdy    <= 1'b0;
              ovalid <= 1'b1;
              state  <= ST_OUT;
            end
          end
        end
        ST_SUM: begin
          acc <= add_res[wsa_pkg::SUM_BITS-1:0];
          k   <= k + wsa_pkg::WIN_BITS'(1);
          if (k == eff_n - wsa_pkg::WIN_BITS'(1)) begin
            if (|rd) begin
              quo   <= {add_res[wsa_pkg::SUM_BITS-1:0], {wsa_pkg::FRAC_BITS{1'b0}}};
              rem   <= '0;
              step  <= '0;
              state <= ST_DIV;
            end else begin
              avg    <= '0;
              rdy    <= 1'b0;
              ovalid <= 1'b1;
              state  <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          quo  <= quo_next;
          step <= step + wsa_pkg::STEP_BITS'(1);
          if (ge) begin
            rem <= add_res[wsa_pkg::WIN_BITS-1:0];
          end else begin
            rem <= shifted[wsa_pkg::WIN_BITS-1:0];
          end
          if (step == wsa_pkg::STEP_BITS'(wsa_pkg::DIV_BITS - 1)) begin
            avg    <= avg_sat;
            rdy    <= 1'b1;
            ovalid <= 1'b1;
            state  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (average.ready) begin
            ovalid <= 1'b0;
            state  <= ST_IDLE;
          end
        end
        default: begin
          ovalid <= 1'b0;
          state  <= ST_IDLE;
        end
      endcase
    end
  end

  assign sensor.ready          = (state == ST_IDLE);
  assign average.valid         = ovalid;
  assign average.average_value = avg;
  assign average.ready_res     = rdy;

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    sensor.ready |-> !average.valid)
    else $error("input ready while a result is pending");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    (average.valid && !average.ready_res) |-> (average.average_value == '0))
    else $error("nonzero average without ready flag");

  a_release: assert property (@(posedge clk) disable iff (rst)
    (average.valid && average.ready) |=> sensor.ready)
    else $error("block not released after result taken");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |-> (32'(k) < wsa_pkg::STORE_DEPTH))
    else $error("summing index beyond store");

endmodule

>>> src/wsa_addsub.sv
module wsa_addsub (
  input  wsa_pkg::operand_t            a,
  input  wsa_pkg::operand_t            b,
  input  logic                         sub,
  output logic [wsa_pkg::ADD_BITS:0]   result
);

  assign result = {1'b0, a} + {1'b0, b ^ {wsa_pkg::ADD_BITS{sub}}}
                  + (wsa_pkg::ADD_BITS + 1)'(sub);

endmodule

>>> test/windowed_sample_average_unit_tb.sv
module windowed_sample_average_unit_tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 60;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_REQUESTS = 1100;
  localparam wsa_pkg::sample_t SAMPLE_MAX = '1;

  typedef struct packed {
    wsa_pkg::average_t average_value;
    logic              ready_res;
  } average_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  wsa_pkg::window_t cfg_data;

  wsa_sample_if sensor_ch ();
  wsa_result_if average_ch ();

  windowed_sample_average_unit uut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .sensor  (sensor_ch),
    .average (average_ch)
  );

  wsa_pkg::sample_t stored_samples [wsa_pkg::STORE_DEPTH];
  logic [3:0]       write_slot;
  wsa_pkg::window_t window_setting;
  average_result_t  expected_averages [$];
  int               mismatches;
  int               cycle_count;
  bit               result_backpressure;
  bit               pattern_open;
  int               pattern_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("windowed_sample_average_unit_tb: errors");
    $finish;
  end

  function automatic average_result_t predict_average(input wsa_pkg::sample_t value);
    int unsigned     span;
    int unsigned     total;
    average_result_t res;
    span = (window_setting > wsa_pkg::STORE_DEPTH) ? wsa_pkg::STORE_DEPTH : window_setting;
    if (span != 0) begin
      if (write_slot >= span) begin
        write_slot = '0;
      end
      stored_samples[write_slot] = value;
    end
    write_slot = write_slot + 4'd1;
    res = '0;
    if (span != 0 && stored_samples[span-1] != '0) begin
      total = 0;
      for (int k = 0; k < span; k++) begin
        total += stored_samples[k];
      end
      total = (total << wsa_pkg::FRAC_BITS) / span;
      if (total > 32'hFFFF) begin
        total = 32'hFFFF;
      end
      res.average_value = total[wsa_pkg::AVG_BITS-1:0];
      res.ready_res = 1'b1;
    end
    return res;
  endfunction

  function automatic wsa_pkg::sample_t draw_sample(input int zero_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < zero_pct) begin
      return '0;
    end
    if (roll < zero_pct + 8) begin
      return SAMPLE_MAX;
    end
    return wsa_pkg::sample_t'($urandom_range(0, SAMPLE_MAX));
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch in %s at cycle %0d: expected %0d, got %0d",
               what, cycle_count, want, got);
    end
  endtask

  // hold valid across back-to-back requests
  task automatic push_sample(input wsa_pkg::sample_t value);
    sensor_ch.valid <= 1'b1;
    sensor_ch.sample <= value;
    do @(posedge clk); while (sensor_ch.ready !== 1'b1);
    expected_averages.push_back(predict_average(value));
  endtask

  task automatic load_window(input wsa_pkg::window_t value);
    sensor_ch.valid <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_setting = value;
  endtask

  task automatic stream_samples(input int count, input int zero_pct, input bit with_gaps);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (with_gaps && burst_left == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
        if (gap > 0) begin
          sensor_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      push_sample(draw_sample(zero_pct));
      burst_left--;
    end
  endtask

  task automatic test_window_zero();
    load_window('0);
    push_sample('0);
    push_sample(SAMPLE_MAX);
    push_sample(wsa_pkg::sample_t'(1));
  endtask

  task automatic test_filling_window();
    load_window(wsa_pkg::window_t'(3));
    push_sample(SAMPLE_MAX);
    push_sample(wsa_pkg::sample_t'(1));
    push_sample(wsa_pkg::sample_t'(2048));
  endtask

  task automatic test_zero_entries();
    result_backpressure = 1'b1;
    push_sample('0);
    push_sample(wsa_pkg::sample_t'(5));
    push_sample('0);
  endtask

  task automatic test_window_extremes();
    load_window(wsa_pkg::window_t'(1));
    push_sample(SAMPLE_MAX);
    push_sample('0);
    push_sample(wsa_pkg::sample_t'(1));
    load_window(wsa_pkg::window_t'(wsa_pkg::STORE_DEPTH));
    repeat (wsa_pkg::STORE_DEPTH) push_sample(SAMPLE_MAX);
  endtask

  task automatic test_oversized_window();
    load_window('1);
    push_sample(wsa_pkg::sample_t'(100));
    push_sample(wsa_pkg::sample_t'(2730));
    // shrink below the current slot to force the wrap
    load_window(wsa_pkg::window_t'(2));
    push_sample(wsa_pkg::sample_t'(7));
  endtask

  task automatic test_random_traffic();
    int               sent;
    int               count;
    wsa_pkg::window_t span;
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      span = ($urandom_range(0, 9) < 7) ? $urandom_range(1, wsa_pkg::STORE_DEPTH)
                                        : $urandom_range(0, 15);
      count = $urandom_range(20, 70);
      load_window(span);
      result_backpressure = ($urandom_range(0, 2) != 0);
      stream_samples(count, ($urandom_range(0, 4) == 0) ? 30 : 3, $urandom_range(0, 3) != 0);
      sent += count;
    end
  endtask

  always @(posedge clk) begin
    if (!result_backpressure) begin
      average_ch.ready <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_open = !pattern_open;
        pattern_left = pattern_open ? $urandom_range(1, 8) : $urandom_range(1, 6);
      end
      pattern_left--;
      average_ch.ready <= pattern_open;
    end
  end

  always @(posedge clk) begin
    average_result_t want;
    if (!rst && average_ch.valid === 1'b1 && average_ch.ready === 1'b1) begin
      if (expected_averages.size() == 0) begin
        flag_mismatch("unexpected result", 0, average_ch.average_value);
      end else begin
        want = expected_averages.pop_front();
        if (average_ch.average_value !== want.average_value) begin
          flag_mismatch("average_value", want.average_value, average_ch.average_value);
        end
        if (average_ch.ready_res !== want.ready_res) begin
          flag_mismatch("ready_res", want.ready_res, average_ch.ready_res);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    sensor_ch.valid = 1'b0;
    sensor_ch.sample = '0;
    average_ch.ready = 1'b0;
    result_backpressure = 1'b0;
    pattern_open = 1'b0;
    pattern_left = 0;
    mismatches = 0;
    cycle_count = 0;
    write_slot = '0;
    window_setting = '0;
    foreach (stored_samples[i]) stored_samples[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_window_zero();
    test_filling_window();
    test_zero_entries();
    test_window_extremes();
    test_oversized_window();
    test_random_traffic();

    sensor_ch.valid <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_averages.size() == 0) begin
      $display("windowed_sample_average_unit_tb: clean");
    end else begin
      $display("windowed_sample_average_unit_tb: errors");
    end
    $finish;
  end

endmodule
